@@ sv/state_vector_gate_engine_assert.svh @@
// Assertion macros used by the gate engine back end.
`ifndef STATE_VECTOR_GATE_ENGINE_ASSERT_SVH
`define STATE_VECTOR_GATE_ENGINE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SVGE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svge: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SVGE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svge: next-cycle check failed");

`endif

@@ sv/svge_pkg.sv @@
// Types and constants shared by the gate engine modules.
package svge_pkg;

  localparam logic [2:0] REQ_INIT = 3'd0;
  localparam logic [2:0] REQ_GATE = 3'd1;
  localparam logic [2:0] REQ_CGATE = 3'd2;
  localparam logic [2:0] REQ_SWAP = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;

  localparam int FRAC_BITS = 14;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
  localparam logic signed [15:0] ONE_Q = 16'sd16384;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_GATE,
    OP_READ,
    OP_REJECT
  } op_t;

  // One classified request, as the back end runs it.
  typedef struct packed {
    op_t              op;
    logic             use_ctl;
    logic             swp;
    logic [3:0]       tq;
    logic [3:0]       cq;
    logic [4:0]       nq;
    logic [9:0]       ridx;
    logic [3:0][15:0] m_re;
    logic [3:0][15:0] m_im;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [17:0]        prob;
    logic               status;
  } res_t;

endpackage

@@ sv/state_vector_gate_engine.sv @@
// Top level of the state vector gate engine.
//
// Requests enter through a queue port: a beat is taken when push is high
// and full is low. Results leave through a queue port: the oldest result
// is shown while empty is low and is taken when pop is high. Every request
// gives exactly one result beat, in request order.
// The qubit count register is written over cfg_valid/cfg_ready/cfg_data;
// write it only while no request is in flight.
// A two-beat command queue parts the front end from the back end, and a
// two-beat result queue parts the back end from the receiver, so requests
// keep being taken while a result waits on a stalled pop.
// The amplitude memory has one read port and one write port. A gate or
// swap reads, multiplies, sums and writes back each amplitude pair it
// touches and steps over each skipped pair; init sweeps all 2^MAX_QUBITS
// entries; a read fetches, saturates, squares and sums one entry.
// Reset empties both queues and sets the qubit count to 1; the amplitude
// contents are undefined until the first init request.
module state_vector_gate_engine #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         req_type,
  input  logic [3:0]         target_qubit,
  input  logic [3:0]         control_qubit,
  input  logic signed [15:0] m0_re,
  input  logic signed [15:0] m0_im,
  input  logic signed [15:0] m1_re,
  input  logic signed [15:0] m1_im,
  input  logic signed [15:0] m2_re,
  input  logic signed [15:0] m2_im,
  input  logic signed [15:0] m3_re,
  input  logic signed [15:0] m3_im,
  input  logic [9:0]         read_index,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] amp_re,
  output logic signed [15:0] amp_im,
  output logic [17:0]        amp_prob,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  logic [3:0]     qubit_count;
  logic           cmd_valid;
  logic           cmd_take;
  svge_pkg::cmd_t cmd;
  logic           rq_full;
  logic           res_push;
  svge_pkg::res_t res;
  svge_pkg::res_t head;

  assign cfg_ready = 1'b1;

  // Hold the qubit count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_count <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      qubit_count <= cfg_data;
    end
  end

  svge_front #(.MAX_QUBITS(MAX_QUBITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .target_qubit (target_qubit),
    .control_qubit(control_qubit),
    .m_re         ({m3_re, m2_re, m1_re, m0_re}),
    .m_im         ({m3_im, m2_im, m1_im, m0_im}),
    .read_index   (read_index),
    .qubit_count  (qubit_count),
    .cmd_valid    (cmd_valid),
    .cmd_take     (cmd_take),
    .cmd          (cmd)
  );

  svge_back #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .rq_full  (rq_full),
    .res_push (res_push),
    .res      (res)
  );

  svge_rq u_rq (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_push),
    .wr_data(res),
    .full   (rq_full),
    .pop    (pop),
    .empty  (empty),
    .head   (head)
  );

  assign amp_re   = head.re;
  assign amp_im   = head.im;
  assign amp_prob = head.prob;
  assign status   = head.status;

endmodule

@@ sv/svge_front.sv @@
// Front end: accepts requests, checks qubit and read indexes and queues commands.
module svge_front #(
  parameter int MAX_QUBITS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       req_type,
  input  logic [3:0]       target_qubit,
  input  logic [3:0]       control_qubit,
  input  logic [3:0][15:0] m_re,
  input  logic [3:0][15:0] m_im,
  input  logic [9:0]       read_index,
  input  logic [3:0]       qubit_count,
  output logic             cmd_valid,
  input  logic             cmd_take,
  output svge_pkg::cmd_t   cmd
);

  logic [4:0]     n_eff;
  logic [16:0]    dim;
  svge_pkg::cmd_t cls;
  svge_pkg::cmd_t q [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;

  // Clamp the qubit count into 1..MAX_QUBITS.
  always_comb begin
    if (qubit_count == 4'd0) begin
      n_eff = 5'd1;
    end else if (5'(qubit_count) > 5'(MAX_QUBITS)) begin
      n_eff = 5'(MAX_QUBITS);
    end else begin
      n_eff = 5'(qubit_count);
    end
  end

  assign dim = 17'(1) << n_eff;

  // Classify the request.
  always_comb begin
    cls         = '0;
    cls.tq      = target_qubit;
    cls.cq      = control_qubit;
    cls.nq      = n_eff;
    cls.ridx    = read_index;
    cls.m_re    = m_re;
    cls.m_im    = m_im;
    cls.op      = svge_pkg::OP_REJECT;
    unique case (req_type)
      svge_pkg::REQ_INIT: begin
        cls.op = svge_pkg::OP_INIT;
      end
      svge_pkg::REQ_GATE: begin
        if (5'(target_qubit) < n_eff) cls.op = svge_pkg::OP_GATE;
      end
      svge_pkg::REQ_CGATE: begin
        cls.use_ctl = 1'b1;
        if (5'(target_qubit) < n_eff && 5'(control_qubit) < n_eff &&
            target_qubit != control_qubit) cls.op = svge_pkg::OP_GATE;
      end
      svge_pkg::REQ_SWAP: begin
        // Swap runs as a controlled pair exchange with an X matrix.
        cls.use_ctl = 1'b1;
        cls.swp     = 1'b1;
        cls.m_re    = {16'd0, svge_pkg::ONE_Q, svge_pkg::ONE_Q, 16'd0};
        cls.m_im    = '0;
        if (5'(target_qubit) < n_eff && 5'(control_qubit) < n_eff)
          cls.op = svge_pkg::OP_GATE;
      end
      svge_pkg::REQ_READ: begin
        if (17'(read_index) < dim) cls.op = svge_pkg::OP_READ;
      end
      default: begin
        cls.op = svge_pkg::OP_REJECT;
      end
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  // Hold classified commands until the back end takes them.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        q[wp] <= cls;
        wp    <= ~wp;
      end
      if (cmd_take) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(cmd_take);
    end
  end

endmodule

@@ sv/svge_rq.sv @@
// Result queue: two beats between the back end and the result port.
module svge_rq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  svge_pkg::res_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output svge_pkg::res_t head
);

  svge_pkg::res_t q [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign head  = q[rp];

  // Advance pointers on write and pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr && !full) begin
        q[wp] <= wr_data;
        wp    <= ~wp;
      end
      if (pop && !empty) rp <= ~rp;
      cnt <= cnt + 2'(wr && !full) - 2'(pop && !empty);
    end
  end

endmodule

@@ sv/svge_back.sv @@
// Back end: amplitude memory and the sequencer that sweeps it per request.
`include "state_vector_gate_engine_assert.svh"

module svge_back #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  svge_pkg::cmd_t cmd,
  output logic           cmd_take,
  input  logic           rq_full,
  output logic           res_push,
  output svge_pkg::res_t res
);

  localparam int AW    = MAX_QUBITS;
  localparam int IW    = AW + 1;
  localparam int DEPTH = 1 << AW;
  localparam int A     = AMP_WIDTH;
  localparam int DW    = 2 * A;
  localparam int PW    = A + 16;
  localparam int SUMW  = PW + 2;
  localparam int SW    = (A > 16) ? A : 17;
  localparam logic signed [A-1:0] AMP_HI  = {1'b0, {(A-1){1'b1}}};
  localparam logic signed [A-1:0] AMP_LO  = {1'b1, {(A-1){1'b0}}};
  localparam logic signed [A-1:0] ONE_AMP =
    (A > 15) ? A'(1 << svge_pkg::FRAC_BITS) : AMP_HI;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RD_REQ, S_RD_CAP, S_RD_SQ, S_RD_SUM,
    S_G_CHK, S_G_RDB, S_G_MUL, S_G_SUM, S_G_WRA, S_G_WRB, S_FIN
  } state_t;

  state_t             state;
  logic               use_ctl;
  logic               swp;
  logic [3:0]         tq;
  logic [3:0]         cq;
  logic [4:0]         nq;
  logic [9:0]         ridx;
  logic [3:0][15:0]   m_re;
  logic [3:0][15:0]   m_im;
  logic [IW-1:0]      cur_i;
  logic [IW-1:0]      partner;
  logic signed [A-1:0] a_re, a_im;
  logic signed [A-1:0] n0_re, n0_im, n1_re, n1_im;
  logic signed [PW-1:0] pr [16];
  logic signed [15:0] res_re, res_im;
  logic [17:0]        res_prob;
  logic               res_status;
  logic [31:0]        sq_re, sq_im;

  logic [DW-1:0]      mem [DEPTH];
  logic [DW-1:0]      rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [AW-1:0]      mem_ra;
  logic [DW-1:0]      mem_wd;

  logic [IW-1:0]      mt, mc, dim, i_adv, pair_j;
  logic               skip;
  logic signed [A-1:0] rd_re, rd_im;
  logic signed [A-1:0] v_re [4];
  logic signed [A-1:0] v_im [4];
  logic signed [SUMW-1:0] ent_re [4];
  logic signed [SUMW-1:0] ent_im [4];

  // Round half up, drop the fraction bits, saturate to the amplitude width.
  function automatic logic signed [A-1:0] rnd_sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] r;
    r = (v + SUMW'(svge_pkg::ROUND_HALF)) >>> svge_pkg::FRAC_BITS;
    if (r > SUMW'(AMP_HI)) return AMP_HI;
    if (r < SUMW'(AMP_LO)) return AMP_LO;
    return r[A-1:0];
  endfunction

  // Saturate a stored amplitude to the 16-bit result width.
  function automatic logic signed [15:0] sat_out(input logic signed [A-1:0] v);
    logic signed [SW-1:0] x;
    x = SW'(v);
    if (x > SW'(32767)) return 16'sh7FFF;
    if (x < -SW'(32768)) return -16'sh8000;
    return x[15:0];
  endfunction

  // Pair addressing: step over indexes with the target bit clear.
  assign mt     = IW'(1) << tq;
  assign mc     = IW'(1) << cq;
  assign dim    = IW'(1) << nq;
  assign i_adv  = ((cur_i | mt) + IW'(1)) & ~mt;
  assign pair_j = swp ? ((cur_i | mt) & ~mc) : (cur_i | mt);
  assign skip   = use_ctl && ((cur_i & mc) == '0);

  assign rd_re = rd_data[DW-1:A];
  assign rd_im = rd_data[A-1:0];

  // Matrix operands: first column meets entry i, second meets entry j.
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      v_re[e]   = (e % 2 == 0) ? a_re : rd_re;
      v_im[e]   = (e % 2 == 0) ? a_im : rd_im;
      ent_re[e] = SUMW'(pr[4*e]) - SUMW'(pr[4*e+1]);
      ent_im[e] = SUMW'(pr[4*e+2]) + SUMW'(pr[4*e+3]);
    end
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_i[AW-1:0];
    mem_wd = {n0_re, n0_im};
    mem_ra = cur_i[AW-1:0];
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wd = (cur_i == '0) ? {ONE_AMP, A'(0)} : '0;
      end
      S_RD_REQ: mem_ra = AW'(ridx);
      S_G_RDB:  mem_ra = partner[AW-1:0];
      S_G_WRA:  mem_we = 1'b1;
      S_G_WRB: begin
        mem_we = 1'b1;
        mem_wa = partner[AW-1:0];
        mem_wd = {n1_re, n1_im};
      end
      default: ;
    endcase
  end

  // Amplitude store, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  assign cmd_take       = (state == S_IDLE) && cmd_valid && !rq_full;
  assign res_push       = (state == S_FIN);
  assign res.re         = res_re;
  assign res.im         = res_im;
  assign res.prob       = res_prob;
  assign res.status     = res_status;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            use_ctl    <= cmd.use_ctl;
            swp        <= cmd.swp;
            tq         <= cmd.tq;
            cq         <= cmd.cq;
            nq         <= cmd.nq;
            ridx       <= cmd.ridx;
            m_re       <= cmd.m_re;
            m_im       <= cmd.m_im;
            cur_i      <= '0;
            res_re     <= '0;
            res_im     <= '0;
            res_prob   <= '0;
            res_status <= (cmd.op == svge_pkg::OP_REJECT);
            unique case (cmd.op)
              svge_pkg::OP_INIT: state <= S_CLR;
              svge_pkg::OP_GATE: state <= S_G_CHK;
              svge_pkg::OP_READ: state <= S_RD_REQ;
              default:           state <= S_FIN;
            endcase
          end
        end
        S_CLR: begin
          cur_i <= cur_i + IW'(1);
          if (cur_i == IW'(DEPTH - 1)) state <= S_FIN;
        end
        S_RD_REQ: state <= S_RD_CAP;
        S_RD_CAP: begin
          res_re <= sat_out(rd_re);
          res_im <= sat_out(rd_im);
          state  <= S_RD_SQ;
        end
        S_RD_SQ: begin
          sq_re <= 32'(32'(res_re) * 32'(res_re));
          sq_im <= 32'(32'(res_im) * 32'(res_im));
          state <= S_RD_SUM;
        end
        S_RD_SUM: begin
          res_prob <= 18'((33'(sq_re) + 33'(sq_im) + 33'(svge_pkg::ROUND_HALF))
                          >> svge_pkg::FRAC_BITS);
          state    <= S_FIN;
        end
        S_G_CHK: begin
          if (cur_i >= dim) begin
            state <= S_FIN;
          end else if (skip) begin
            cur_i <= i_adv;
          end else begin
            partner <= pair_j;
            state   <= S_G_RDB;
          end
        end
        S_G_RDB: begin
          a_re  <= rd_re;
          a_im  <= rd_im;
          state <= S_G_MUL;
        end
        S_G_MUL: begin
          for (int e = 0; e < 4; e++) begin
            pr[4*e]   <= PW'($signed(m_re[e])) * PW'(v_re[e]);
            pr[4*e+1] <= PW'($signed(m_im[e])) * PW'(v_im[e]);
            pr[4*e+2] <= PW'($signed(m_re[e])) * PW'(v_im[e]);
            pr[4*e+3] <= PW'($signed(m_im[e])) * PW'(v_re[e]);
          end
          state <= S_G_SUM;
        end
        S_G_SUM: begin
          n0_re <= rnd_sat(ent_re[0] + ent_re[1]);
          n0_im <= rnd_sat(ent_im[0] + ent_im[1]);
          n1_re <= rnd_sat(ent_re[2] + ent_re[3]);
          n1_im <= rnd_sat(ent_im[2] + ent_im[3]);
          state <= S_G_WRA;
        end
        S_G_WRA: state <= S_G_WRB;
        S_G_WRB: begin
          cur_i <= i_adv;
          state <= S_G_CHK;
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `SVGE_ASSERT_IMP(a_push_room, res_push, !rq_full)
  `SVGE_ASSERT_NEXT(a_take_busy, cmd_take, state != S_IDLE)
  `SVGE_ASSERT_IMP(a_lower_clear, state == S_G_RDB, (cur_i & mt) == '0)
  `SVGE_ASSERT_IMP(a_partner_range, state == S_G_WRB, partner < dim)

endmodule
